@@ rtl/core/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helper functions for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int STEP_W = 5;
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 22;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int TRIG_W = 23;

    localparam logic [MUL_BW-1:0] HEAD_GAIN   = 22'd2734261;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [15:0]       TICK_MAX    = 16'hFFFF;
    localparam logic [31:0]       ANGLE_PI    = 32'h8000_0000;
    localparam logic [7:0]        DIV_BASE    = 8'd125;
    localparam logic [23:0]       DIV_RECIP   = 24'd8589935;
    localparam int                DIV_RSH     = 30;
    localparam int                X_START_MM  = -850;
    localparam int                Y_START_MM  = 620;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_GAIN,
        ST_VEL,
        ST_TRIG_GO,
        ST_TRIG,
        ST_X,
        ST_Y,
        ST_DIV,
        ST_RESULT
    } state_t;

    typedef enum logic {
        CMD_UPDATE  = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            default: r = 32'h00000001;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] start_pos(input int mm, input int frac);
        logic signed [63:0] v;
        v = 64'(signed'(mm)) <<< frac;
        return sat32(v);
    endfunction

endpackage

@@ rtl/core/ddo_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ddo_cfg_if
// Configuration write channel carrying the start side.
// ----------------------------------------------------------------------------
interface ddo_cfg_if;
    logic valid;
    logic ready;
    logic team_side;

    modport source (output valid, output team_side, input ready);
    modport sink   (input valid, input team_side, output ready);
endinterface

@@ rtl/core/ddo_upd_if.sv @@
// ----------------------------------------------------------------------------
// ddo_upd_if
// Update channel: command, wheel speeds and wheel timer stamps.
// ----------------------------------------------------------------------------
interface ddo_upd_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] right_speed;
    logic signed [15:0] left_speed;
    logic [31:0]        left_stamp;
    logic [31:0]        right_stamp;

    modport source (output valid, output cmd, output right_speed, output left_speed,
                    output left_stamp, output right_stamp, input ready);
    modport sink   (input valid, input cmd, input right_speed, input left_speed,
                    input left_stamp, input right_stamp, output ready);
endinterface

@@ rtl/core/ddo_pose_if.sv @@
// ----------------------------------------------------------------------------
// ddo_pose_if
// Pose result channel.
// ----------------------------------------------------------------------------
interface ddo_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

@@ rtl/core/ddo_mul.sv @@
// ----------------------------------------------------------------------------
// ddo_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                        clk,
    input  logic [ddo_pkg::MUL_AW-1:0]  a,
    input  logic [ddo_pkg::MUL_BW-1:0]  b,
    output logic [ddo_pkg::MUL_PW-1:0]  prod
);

    logic [ddo_pkg::MUL_PW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= ddo_pkg::MUL_PW'(a) * ddo_pkg::MUL_PW'(b);
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC rotation, one step per cycle, cos and sin in Q20.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [31:0]                       angle,
    output logic                              done,
    output logic signed [ddo_pkg::TRIG_W-1:0] cos_q20,
    output logic signed [ddo_pkg::TRIG_W-1:0] sin_q20
);

    logic signed [32:0]               x_reg, y_reg, z_reg;
    logic [ddo_pkg::STEP_W-1:0]       cnt_reg;
    logic                             busy_reg, done_reg, flip_reg;
    logic signed [32:0]               x_sh, y_sh, atan_s;
    logic [31:0]                      a_rot;
    logic signed [33:0]               x_rnd, y_rnd;
    logic signed [ddo_pkg::TRIG_W-1:0] x_q20, y_q20;

    always_comb
    begin
        x_sh   = x_reg >>> cnt_reg;
        y_sh   = y_reg >>> cnt_reg;
        atan_s = signed'({1'b0, ddo_pkg::atan_entry(cnt_reg)});
        a_rot  = (angle[31] ^ angle[30]) ? angle + ddo_pkg::ANGLE_PI : angle;
        x_rnd  = 34'(x_reg) + 34'sd512;
        y_rnd  = 34'(y_reg) + 34'sd512;
        x_q20  = ddo_pkg::TRIG_W'(x_rnd >>> 10);
        y_q20  = ddo_pkg::TRIG_W'(y_rnd >>> 10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ddo_pkg::STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= angle[31] ^ angle[30];
            x_reg    <= ddo_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= signed'({a_rot[31], a_rot});
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_s;
            end
        end
    end

    assign done    = done_reg;
    assign cos_q20 = flip_reg ? -x_q20 : x_q20;
    assign sin_q20 = flip_reg ? -y_q20 : y_q20;

endmodule

@@ rtl/core/ddo_div.sv @@
// ----------------------------------------------------------------------------
// ddo_div
// Rounded scaling of a position product: shift, then divide by 125 in 16-bit
// digits, each digit by a reciprocal multiply and a remainder step.
// ----------------------------------------------------------------------------
module ddo_div #(
    parameter int POS_FRAC_BITS = ddo_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ddo_pkg::MUL_PW-1:0]  mag,
    output logic                        done,
    output logic [24+POS_FRAC_BITS-1:0] quo
);

    localparam int NW = 24 + POS_FRAC_BITS;
    localparam int CH = (NW + 15) / 16;
    localparam int PW = CH * 16;
    localparam int NS = 2 * CH;
    localparam int CW = $clog2(NS);
    localparam int SH = 34 - POS_FRAC_BITS;

    logic [PW-1:0]              sh_reg;
    logic [6:0]                 rem_reg;
    logic [22:0]                xd_reg;
    logic [15:0]                qd_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg, done_reg;
    logic [ddo_pkg::MUL_PW-1:0] rnd;
    logic [22:0]                xd;
    logic [46:0]                qprod;
    logic [22:0]                back;
    logic [6:0]                 rem_n;

    always_comb
    begin
        rnd   = mag + (ddo_pkg::MUL_PW'(ddo_pkg::DIV_BASE) << (SH - 1));
        xd    = {rem_reg, sh_reg[PW-1 -: 16]};
        qprod = 47'(xd) * 47'(ddo_pkg::DIV_RECIP);
        back  = 23'(qd_reg) * 23'(ddo_pkg::DIV_BASE);
        rem_n = 7'(xd_reg - back);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(NS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // even step: digit estimate, odd step: remainder and shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= PW'(rnd[SH +: NW]);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[0])
            begin
                xd_reg <= xd;
                qd_reg <= qprod[ddo_pkg::DIV_RSH +: 16];
            end
            else
            begin
                sh_reg  <= {sh_reg[PW-17:0], qd_reg};
                rem_reg <= rem_n;
            end
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg[NW-1:0];

endmodule

@@ rtl/core/diff_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning pose tracker for a two-wheel robot.
//
//   channel  dir  handshake     payload
//   cfg      in   valid/ready   team_side
//   upd      in   valid/ready   cmd, right_speed, left_speed, left_stamp, right_stamp
//   pose     out  valid/ready   pos_x, pos_y, heading
//
// an update runs through the diff, gain, velocity, trig start, cordic step loop,
// x, y and divide-by-125 digit steps before the result state; a restart goes
// straight from idle to the result state
// upd.ready is high only when the sequencer is idle; cfg is always ready
// a finished pose waits in the output register; a new transfer is taken meanwhile
// reset loads the blue start pose and clears both stamps
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
    parameter int CORDIC_STEPS  = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = ddo_pkg::POS_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ddo_cfg_if.sink     cfg,
    ddo_upd_if.sink     upd,
    ddo_pose_if.source  pose
);

    localparam int NW = 24 + POS_FRAC_BITS;
    localparam logic [31:0] X_START  = ddo_pkg::start_pos(ddo_pkg::X_START_MM, POS_FRAC_BITS);
    localparam logic [31:0] Y_BLUE   = ddo_pkg::start_pos(-ddo_pkg::Y_START_MM, POS_FRAC_BITS);
    localparam logic [31:0] Y_YELLOW = ddo_pkg::start_pos(ddo_pkg::Y_START_MM, POS_FRAC_BITS);

    ddo_pkg::state_t state_reg, state_next;

    logic        team_side_reg;
    logic [31:0] pose_x_reg, pose_y_reg, angle_reg;
    logic [31:0] last_l_reg, last_r_reg;
    logic [15:0] ticks_reg, dmag_reg;
    logic        dneg_reg, vneg_reg, xneg_reg, yneg_reg;
    logic [19:0] vmag_reg;
    logic [35:0] tmag_reg;
    logic [ddo_pkg::MUL_PW-1:0] px_reg;
    logic        out_valid_reg;
    logic [31:0] out_x_reg, out_y_reg;
    logic [15:0] out_h_reg;

    logic        accept, out_free;
    logic [31:0] dl, dr, tsum;
    logic [15:0] ticks_in;
    logic signed [16:0] diff, sumw;
    logic [16:0] diff_mag, sum_mag;
    logic [20:0] v15;
    logic [47:0] gain_rnd;
    logic [31:0] dang;
    logic [ddo_pkg::MUL_AW-1:0] mul_a;
    logic [ddo_pkg::MUL_BW-1:0] mul_b;
    logic [ddo_pkg::MUL_PW-1:0] prod;
    logic        trig_start, trig_done, div_start, div_done, div_y_done;
    logic signed [ddo_pkg::TRIG_W-1:0] cos_q20, sin_q20;
    logic [ddo_pkg::TRIG_W-1:0] cmag, smag;
    logic [NW-1:0] qx, qy;
    logic signed [63:0] x_sum, y_sum;

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (trig_start),
        .angle   (angle_reg),
        .done    (trig_done),
        .cos_q20 (cos_q20),
        .sin_q20 (sin_q20)
    );

    ddo_div #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (px_reg),
        .done  (div_done),
        .quo   (qx)
    );

    // the sine product is still on the multiplier output at the start
    ddo_div #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (prod),
        .done  (div_y_done),
        .quo   (qy)
    );

    // input decode and step arithmetic
    always_comb
    begin
        dl       = upd.left_stamp - last_l_reg;
        dr       = upd.right_stamp - last_r_reg;
        tsum     = dl + dr;
        ticks_in = (|tsum[31:16]) ? ddo_pkg::TICK_MAX : tsum[15:0];
        diff     = 17'(upd.right_speed) - 17'(upd.left_speed);
        sumw     = 17'(upd.right_speed) + 17'(upd.left_speed);
        diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
        sum_mag  = sumw[16] ? 17'(-sumw) : 17'(sumw);
        v15      = (21'(sum_mag) << 4) - 21'(sum_mag);
        gain_rnd = prod[47:0] + 48'd32768;
        dang     = gain_rnd[47:16];
        cmag     = cos_q20[ddo_pkg::TRIG_W-1] ? ddo_pkg::TRIG_W'(-cos_q20)
                                              : ddo_pkg::TRIG_W'(cos_q20);
        smag     = sin_q20[ddo_pkg::TRIG_W-1] ? ddo_pkg::TRIG_W'(-sin_q20)
                                              : ddo_pkg::TRIG_W'(sin_q20);
        x_sum    = 64'(signed'(pose_x_reg)) + (xneg_reg ? -64'(qx) : 64'(qx));
        y_sum    = 64'(signed'(pose_y_reg)) + (yneg_reg ? -64'(qy) : 64'(qy));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:
                if (upd.valid)
                    state_next = (upd.cmd == ddo_pkg::CMD_RESTART) ? ddo_pkg::ST_RESULT
                                                                   : ddo_pkg::ST_DIFF;
            ddo_pkg::ST_DIFF:    state_next = ddo_pkg::ST_GAIN;
            ddo_pkg::ST_GAIN:    state_next = ddo_pkg::ST_VEL;
            ddo_pkg::ST_VEL:     state_next = ddo_pkg::ST_TRIG_GO;
            ddo_pkg::ST_TRIG_GO: state_next = ddo_pkg::ST_TRIG;
            ddo_pkg::ST_TRIG:
                if (trig_done)
                    state_next = ddo_pkg::ST_X;
            ddo_pkg::ST_X:       state_next = ddo_pkg::ST_Y;
            ddo_pkg::ST_Y:       state_next = ddo_pkg::ST_DIV;
            ddo_pkg::ST_DIV:
                if (div_done && div_y_done)
                    state_next = ddo_pkg::ST_RESULT;
            ddo_pkg::ST_RESULT:
                if (out_free)
                    state_next = ddo_pkg::ST_IDLE;
            default:             state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        trig_start = 1'b0;
        div_start  = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:
                accept = upd.valid;
            ddo_pkg::ST_DIFF:
            begin
                mul_a = ddo_pkg::MUL_AW'(dmag_reg);
                mul_b = ddo_pkg::MUL_BW'(ticks_reg);
            end
            ddo_pkg::ST_GAIN:
            begin
                mul_a = ddo_pkg::MUL_AW'(prod[31:0]);
                mul_b = ddo_pkg::HEAD_GAIN;
            end
            ddo_pkg::ST_VEL:
            begin
                mul_a = ddo_pkg::MUL_AW'(vmag_reg);
                mul_b = ddo_pkg::MUL_BW'(ticks_reg);
            end
            ddo_pkg::ST_TRIG_GO:
                trig_start = 1'b1;
            ddo_pkg::ST_TRIG:
            begin
                mul_a = tmag_reg;
                mul_b = ddo_pkg::MUL_BW'(cmag);
            end
            ddo_pkg::ST_X:
            begin
                mul_a = tmag_reg;
                mul_b = ddo_pkg::MUL_BW'(smag);
            end
            ddo_pkg::ST_Y:
                div_start = 1'b1;
            default:
                ;
        endcase
    end

    assign out_free = !out_valid_reg || pose.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ddo_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // pose state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            team_side_reg <= 1'b0;
            pose_x_reg    <= X_START;
            pose_y_reg    <= Y_BLUE;
            angle_reg     <= ddo_pkg::ANGLE_PI;
            last_l_reg    <= '0;
            last_r_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                team_side_reg <= cfg.team_side;
            if (accept)
            begin
                last_l_reg <= upd.left_stamp;
                last_r_reg <= upd.right_stamp;
                if (upd.cmd == ddo_pkg::CMD_RESTART)
                begin
                    pose_x_reg <= X_START;
                    pose_y_reg <= team_side_reg ? Y_YELLOW : Y_BLUE;
                    angle_reg  <= ddo_pkg::ANGLE_PI;
                end
            end
            if (state_reg == ddo_pkg::ST_VEL)
                angle_reg <= dneg_reg ? angle_reg - dang : angle_reg + dang;
            if (state_reg == ddo_pkg::ST_DIV && div_done && div_y_done)
            begin
                pose_x_reg <= ddo_pkg::sat32(x_sum);
                pose_y_reg <= ddo_pkg::sat32(y_sum);
            end
            if (state_reg == ddo_pkg::ST_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (pose.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ticks_reg <= ticks_in;
            dmag_reg  <= diff_mag[15:0];
            dneg_reg  <= diff[16];
            vmag_reg  <= v15[19:0];
            vneg_reg  <= sumw[16];
        end
        if (state_reg == ddo_pkg::ST_TRIG_GO)
            tmag_reg <= prod[35:0];
        if (state_reg == ddo_pkg::ST_X)
        begin
            px_reg   <= prod;
            xneg_reg <= vneg_reg ^ cos_q20[ddo_pkg::TRIG_W-1];
        end
        if (state_reg == ddo_pkg::ST_Y)
            yneg_reg <= vneg_reg ^ sin_q20[ddo_pkg::TRIG_W-1];
        if (state_reg == ddo_pkg::ST_RESULT && out_free)
        begin
            out_x_reg <= pose_x_reg;
            out_y_reg <= pose_y_reg;
            out_h_reg <= angle_reg[31:16];
        end
    end

    assign cfg.ready    = 1'b1;
    assign upd.ready    = (state_reg == ddo_pkg::ST_IDLE);
    assign pose.valid   = out_valid_reg;
    assign pose.pos_x   = signed'(out_x_reg);
    assign pose.pos_y   = signed'(out_y_reg);
    assign pose.heading = signed'(out_h_reg);

endmodule
